// File: rtl/gn2d_pkg.sv
// Shared constants, types and the gradient lookup table for the 2D gradient noise block.
// No dependencies; every other file except gn2d_chk imports this package.
package gn2d_pkg;

  localparam int ANGLE_BITS = 10;
  localparam int FRAC_BITS  = 16;
  localparam int ONE        = 2 ** FRAC_BITS;

  localparam logic [31:0] HASH_M1 = 32'd3284157443;
  localparam logic [31:0] HASH_M2 = 32'd1911520717;
  localparam logic [31:0] HASH_M3 = 32'd2048419325;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // gradient component width (Q1.14 magnitude, 0..16384) and signed form
  localparam int CW    = 15;
  localparam int GW    = CW + 1;
  localparam int TAB_N = 2 ** (ANGLE_BITS - 2);

  localparam int NW = FRAC_BITS + 4;   // corner dot / blend values
  localparam int FW = FRAC_BITS + 6;   // fade polynomial

  localparam int QDEPTH   = 4;
  localparam int QAW      = 2;
  localparam int ODEPTH   = 16;
  localparam int OAW      = 4;
  localparam int PIPE_LEN = 10;

  localparam logic [1:0] QUAD0 = 2'd0;
  localparam logic [1:0] QUAD1 = 2'd1;
  localparam logic [1:0] QUAD2 = 2'd2;

  typedef struct packed {
    logic [31:0]          x0;
    logic [31:0]          y0;
    logic [FRAC_BITS-1:0] fx;
    logic [FRAC_BITS-1:0] fy;
  } cell_t;

  typedef logic [2*CW-1:0] gtab_t [TAB_N];

  // {cos, sin} of the first quadrant angles, Taylor series in Q2.30, rounded to Q1.14
  function automatic gtab_t build_gtab();
    gtab_t                tab;
    longint unsigned      frac;
    longint unsigned      theta;
    longint unsigned      th2;
    longint unsigned      term;
    longint               s_sum;
    longint               c_sum;
    longint               cq;
    longint               sq;
    for (int i = 0; i < TAB_N; i++) begin
      frac  = 64'(i) << (32 - ANGLE_BITS);
      theta = (frac * HALF_PI_Q30) >> 30;
      th2   = (theta * theta) >> 30;
      term  = theta;
      s_sum = $signed(term);
      for (int n = 1; n <= 4; n++) begin
        term  = ((term * th2) >> 30) / 64'((2 * n) * (2 * n + 1));
        s_sum = (n % 2 == 1) ? s_sum - $signed(term) : s_sum + $signed(term);
      end
      term  = 64'd1 << 30;
      c_sum = $signed(term);
      for (int n = 1; n <= 5; n++) begin
        term  = ((term * th2) >> 30) / 64'((2 * n - 1) * (2 * n));
        c_sum = (n % 2 == 1) ? c_sum - $signed(term) : c_sum + $signed(term);
      end
      cq = (c_sum + 64'sd32768) >>> 16;
      sq = (s_sum + 64'sd32768) >>> 16;
      if (cq < 0) cq = 0;
      if (cq > 16384) cq = 16384;
      if (sq < 0) sq = 0;
      if (sq > 16384) sq = 16384;
      tab[i] = {cq[CW-1:0], sq[CW-1:0]};
    end
    return tab;
  endfunction

  localparam gtab_t GTAB = build_gtab();

endpackage

// File: rtl/gn2d_front.sv
// Input stage: takes a beat, splits the point into lattice cell and fraction.
// Depends on gn2d_pkg.
module gn2d_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  logic signed [31:0]    x_coord,
  input  logic signed [31:0]    y_coord,
  input  logic                  q_full,
  output logic                  q_wr,
  output gn2d_pkg::cell_t       q_data
);
  import gn2d_pkg::*;

  logic  fv;
  logic  fv_next;
  cell_t fcell;

  assign full    = fv && q_full;
  assign q_wr    = fv && !q_full;
  assign q_data  = fcell;
  assign fv_next = (fv && q_full) || (push && !full);

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else begin
      fv <= fv_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      fcell.x0 <= x_coord >>> FRAC_BITS;
      fcell.y0 <= y_coord >>> FRAC_BITS;
      fcell.fx <= x_coord[FRAC_BITS-1:0];
      fcell.fy <= y_coord[FRAC_BITS-1:0];
    end
  end

endmodule

// File: rtl/gn2d_queue.sv
// Short queue of split points between the input stage and the noise pipeline.
// Depends on gn2d_pkg.
module gn2d_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr,
  input  gn2d_pkg::cell_t wr_data,
  input  logic            rd,
  output logic            full,
  output logic            empty,
  output gn2d_pkg::cell_t head
);
  import gn2d_pkg::*;

  cell_t          mem [QDEPTH];
  logic [QAW-1:0] wp;
  logic [QAW-1:0] rp;
  logic [QAW:0]   cnt;

  assign full  = (cnt == (QAW+1)'(QDEPTH));
  assign empty = (cnt == '0);
  assign head  = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (wr) wp <= wp + 1'b1;
      if (rd) rp <= rp + 1'b1;
      cnt <= cnt + (QAW+1)'(wr) - (QAW+1)'(rd);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem[wp] <= wr_data;
  end

endmodule

// File: rtl/gn2d_back.sv
// Noise pipeline: corner hashes, gradient lookup, dot products, fade and blend,
// output mapping and result queue with credit-based issue. Depends on gn2d_pkg.
module gn2d_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_empty,
  input  gn2d_pkg::cell_t q_head,
  output logic            q_rd,
  input  logic            pop,
  output logic            empty,
  output logic [15:0]     noise_value
);
  import gn2d_pkg::*;

  localparam int F   = FRAC_BITS;
  localparam int SH  = F - 15;
  localparam int RSH = (SH > 0) ? SH : 0;
  localparam int LSH = (SH < 0) ? -SH : 0;
  localparam int UW  = NW + 9;

  function automatic logic [31:0] rot16(input logic [31:0] v);
    return {v[15:0], v[31:16]};
  endfunction

  function automatic logic signed [FW-1:0] fmul(input logic signed [FW-1:0] t,
                                                 input logic [F-1:0] w);
    logic signed [FW+F:0] p;
    p = t * $signed({1'b0, w});
    p = p + (FW+F+1)'(2 ** (F - 1));
    return FW'(p >>> F);
  endfunction

  logic [PIPE_LEN-1:0] vld;
  logic [OAW:0]        cred;
  logic                popd;

  // stage 1
  logic [31:0]           s1_ax [2];
  logic [31:0]           s1_y  [2];
  logic [F-1:0]          s1_fx, s1_fy;
  logic signed [FW-1:0]  s1_tx, s1_ty;
  // stage 2
  logic [31:0]           s2_ax [2];
  logic [31:0]           s2_b  [4];
  logic [F-1:0]          s2_fx, s2_fy;
  logic signed [FW-1:0]  s2_tx, s2_ty;
  // stage 3
  logic [31:0]           s3_a  [4];
  logic [F-1:0]          s3_fx, s3_fy;
  logic signed [FW-1:0]  s3_tx, s3_ty;
  // stage 4
  logic signed [GW-1:0]  s4_gx [4];
  logic signed [GW-1:0]  s4_gy [4];
  logic [F-1:0]          s4_fx, s4_fy;
  logic signed [FW-1:0]  s4_tx, s4_ty;
  // stage 5
  logic signed [F+GW:0]  s5_px [4];
  logic signed [F+GW:0]  s5_py [4];
  logic [F:0]            s5_sx, s5_sy;
  // stage 6
  logic signed [NW-1:0]  s6_n  [4];
  logic [F:0]            s6_sx, s6_sy;
  // stage 7
  logic signed [NW+F+1:0] s7_p  [2];
  logic signed [NW-1:0]   s7_n0 [2];
  logic [F:0]             s7_sy;
  // stage 8
  logic signed [NW-1:0]   s8_r [2];
  logic [F:0]             s8_sy;
  // stage 9
  logic signed [NW+F+1:0] s9_p;
  logic signed [NW-1:0]   s9_r0;
  // stage 10
  logic signed [NW-1:0]   s10_v;

  logic signed [FW-1:0]  t5x, t5y;
  logic [F:0]            sxc, syc;
  logic signed [NW:0]    u;
  logic [UW-1:0]         uw;
  logic [UW-1:0]         us;
  logic [15:0]           res;

  logic [15:0]    ofifo [ODEPTH];
  logic [OAW-1:0] owp, orp;
  logic [OAW:0]   ocnt;

  assign popd  = pop && (ocnt != '0);
  assign q_rd  = !q_empty && (cred < (OAW+1)'(ODEPTH));
  assign empty = (ocnt == '0);
  assign noise_value = ofifo[orp];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      cred <= '0;
    end else begin
      vld  <= {vld[PIPE_LEN-2:0], q_rd};
      cred <= cred + (OAW+1)'(q_rd) - (OAW+1)'(popd);
    end
  end

  // fade end clamp to 0..ONE
  assign t5x = fmul(s4_tx, s4_fx);
  assign t5y = fmul(s4_ty, s4_fy);
  always_comb begin
    if (t5x < 0) sxc = '0;
    else if (t5x > FW'(ONE)) sxc = (F+1)'(ONE);
    else sxc = t5x[F:0];
    if (t5y < 0) syc = '0;
    else if (t5y > FW'(ONE)) syc = (F+1)'(ONE);
    else syc = t5y[F:0];
  end

  always_ff @(posedge clk) begin
    // stage 1: first hash multiply per column, fade start
    s1_ax[0] <= q_head.x0 * HASH_M1;
    s1_ax[1] <= (q_head.x0 + 32'd1) * HASH_M1;
    s1_y[0]  <= q_head.y0;
    s1_y[1]  <= q_head.y0 + 32'd1;
    s1_fx    <= q_head.fx;
    s1_fy    <= q_head.fy;
    s1_tx    <= $signed(FW'({q_head.fx, 2'b00}) + FW'({q_head.fx, 1'b0}) - FW'(15 * ONE));
    s1_ty    <= $signed(FW'({q_head.fy, 2'b00}) + FW'({q_head.fy, 1'b0}) - FW'(15 * ONE));
    // stage 2; corner c: bit 0 picks x1, bit 1 picks y1
    for (int c = 0; c < 4; c++) begin
      s2_b[c] <= (s1_y[c/2] ^ rot16(s1_ax[c%2])) * HASH_M2;
    end
    s2_ax <= s1_ax;
    s2_fx <= s1_fx;
    s2_fy <= s1_fy;
    s2_tx <= fmul(s1_tx, s1_fx) + FW'(10 * ONE);
    s2_ty <= fmul(s1_ty, s1_fy) + FW'(10 * ONE);
    // stage 3
    for (int c = 0; c < 4; c++) begin
      s3_a[c] <= (s2_ax[c%2] ^ rot16(s2_b[c])) * HASH_M3;
    end
    s3_fx <= s2_fx;
    s3_fy <= s2_fy;
    s3_tx <= fmul(s2_tx, s2_fx);
    s3_ty <= fmul(s2_ty, s2_fy);
    // stage 4: gradient from table, rotated by quadrant
    for (int c = 0; c < 4; c++) begin
      logic [2*CW-1:0]      e;
      logic signed [GW-1:0] gc;
      logic signed [GW-1:0] gs;
      e  = GTAB[s3_a[c][31-2 -: ANGLE_BITS-2]];
      gc = $signed({1'b0, e[2*CW-1:CW]});
      gs = $signed({1'b0, e[CW-1:0]});
      case (s3_a[c][31 -: 2])
        QUAD0: begin
          s4_gx[c] <= gc;
          s4_gy[c] <= gs;
        end
        QUAD1: begin
          s4_gx[c] <= -gs;
          s4_gy[c] <= gc;
        end
        QUAD2: begin
          s4_gx[c] <= -gc;
          s4_gy[c] <= -gs;
        end
        default: begin
          s4_gx[c] <= gs;
          s4_gy[c] <= -gc;
        end
      endcase
    end
    s4_fx <= s3_fx;
    s4_fy <= s3_fy;
    s4_tx <= fmul(s3_tx, s3_fx);
    s4_ty <= fmul(s3_ty, s3_fy);
    // stage 5: offset times gradient; far offset is fx - ONE = {1, fx}
    for (int c = 0; c < 4; c++) begin
      s5_px[c] <= $signed({c % 2 == 1, s4_fx}) * s4_gx[c];
      s5_py[c] <= $signed({c / 2 == 1, s4_fy}) * s4_gy[c];
    end
    s5_sx <= sxc;
    s5_sy <= syc;
    // stage 6
    for (int c = 0; c < 4; c++) begin
      s6_n[c] <= NW'(((F+GW+2)'(s5_px[c]) + (F+GW+2)'(s5_py[c])
                      + (F+GW+2)'(2 ** 13)) >>> 14);
    end
    s6_sx <= s5_sx;
    s6_sy <= s5_sy;
    // stage 7: blend along x
    for (int r = 0; r < 2; r++) begin
      s7_p[r]  <= ((NW+1)'(s6_n[2*r+1]) - (NW+1)'(s6_n[2*r])) * $signed({1'b0, s6_sx});
      s7_n0[r] <= s6_n[2*r];
    end
    s7_sy <= s6_sy;
    // stage 8
    for (int r = 0; r < 2; r++) begin
      s8_r[r] <= s7_n0[r] + NW'((s7_p[r] + (NW+F+2)'(2 ** (F - 1))) >>> F);
    end
    s8_sy <= s7_sy;
    // stage 9: blend along y
    s9_p  <= ((NW+1)'(s8_r[1]) - (NW+1)'(s8_r[0])) * $signed({1'b0, s8_sy});
    s9_r0 <= s8_r[0];
    // stage 10
    s10_v <= s9_r0 + NW'((s9_p + (NW+F+2)'(2 ** (F - 1))) >>> F);
  end

  // map [-1,1] to a 16-bit fraction
  assign u  = (NW+1)'(s10_v) + (NW+1)'(ONE);
  assign uw = UW'(u);

  generate
    if (RSH > 0) begin : g_rsh
      assign us = (uw + UW'(2 ** (RSH - 1))) >> RSH;
    end else begin : g_lsh
      assign us = uw << LSH;
    end
  endgenerate

  always_comb begin
    if (u <= 0) res = '0;
    else if (us > UW'(16'hFFFF)) res = 16'hFFFF;
    else res = us[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owp  <= '0;
      orp  <= '0;
      ocnt <= '0;
    end else begin
      if (vld[PIPE_LEN-1]) owp <= owp + 1'b1;
      if (popd) orp <= orp + 1'b1;
      ocnt <= ocnt + (OAW+1)'(vld[PIPE_LEN-1]) - (OAW+1)'(popd);
    end
  end

  always_ff @(posedge clk) begin
    if (vld[PIPE_LEN-1]) ofifo[owp] <= res;
  end

endmodule

// File: rtl/gradient_noise_2d_top.sv
// 2D gradient noise, top level. An accepted push beat passes the input register, the
// point queue, the 10-stage noise pipeline and the result queue before it shows (empty
// low). Throughput: one point per cycle; issue stalls only on result-queue credits.
// Reset (rst, synchronous) clears all valid and pointer state; queued items are dropped.
// Depends on gn2d_pkg, gn2d_front, gn2d_queue, gn2d_back.
module gradient_noise_2d_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic signed [31:0] x_coord,
  input  logic signed [31:0] y_coord,
  input  logic               pop,
  output logic               empty,
  output logic [15:0]        noise_value
);
  import gn2d_pkg::*;

  logic  q_full;
  logic  q_empty;
  logic  q_wr;
  logic  q_rd;
  cell_t q_data;
  cell_t q_head;

  gn2d_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .x_coord (x_coord),
    .y_coord (y_coord),
    .q_full  (q_full),
    .q_wr    (q_wr),
    .q_data  (q_data)
  );

  gn2d_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_wr),
    .wr_data (q_data),
    .rd      (q_rd),
    .full    (q_full),
    .empty   (q_empty),
    .head    (q_head)
  );

  gn2d_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_head      (q_head),
    .q_rd        (q_rd),
    .pop         (pop),
    .empty       (empty),
    .noise_value (noise_value)
  );

endmodule

// File: rtl/gn2d_chk.sv
// Port-level checks for gradient_noise_2d_top, attached by bind.
// No package dependency.
module gn2d_chk (
  input logic        clk,
  input logic        rst,
  input logic        push,
  input logic        full,
  input logic        pop,
  input logic        empty,
  input logic [15:0] noise_value
);

  // reset flushes everything
  a_rst_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("results left after reset");

  a_rst_full: assert property (@(posedge clk) rst |=> !full)
    else $error("input blocked after reset");

  // no result can appear at once after an idle reset
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    ($past(rst) && !push) |=> empty)
    else $error("result appeared without input");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> !empty)
    else $error("waiting result dropped");

  a_stable: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> $stable(noise_value))
    else $error("waiting result changed");

endmodule

bind gradient_noise_2d_top gn2d_chk u_chk (.*);

// File: verif/tb_gradient_noise_2d_top.sv
// Self-checking bench for gradient_noise_2d_top: a bit-exact Perlin noise
// predictor in a scoreboard class, queue-style push/pop drivers and random idling.
// Depends on gn2d_pkg and the gradient_noise_2d_top RTL.
module tb_gradient_noise_2d_top;
  import gn2d_pkg::*;

  class noise_scoreboard;
    logic [15:0] expected_noise [$];
    int errors;

    function new();
      errors = 0;
    endfunction

    function longint round_shift(longint v, int n);
      return (v + (longint'(1) << (n - 1))) >>> n;
    endfunction

    function bit [31:0] mix_hash(bit [31:0] cx, bit [31:0] cy);
      bit [31:0] a, b;
      a = cx * HASH_M1;
      b = cy ^ {a[15:0], a[31:16]};
      b = b * HASH_M2;
      a = a ^ {b[15:0], b[31:16]};
      a = a * HASH_M3;
      return a;
    endfunction

    function longint clamp_q14(longint s);
      longint r;
      r = (s + 32768) >>> 16;
      if (r < 0) r = 0;
      if (r > 16384) r = 16384;
      return r;
    endfunction

    // gradient from the hash: quadrant plus a Taylor cos/sin of the remainder
    function void gradient(bit [31:0] h, output longint gx, output longint gy);
      bit [ANGLE_BITS-1:0] k;
      longint unsigned theta, th2, term;
      longint s_acc, c_acc, c, s;
      k = h[31 -: ANGLE_BITS];
      theta = ((longint'(k[ANGLE_BITS-3:0]) << (32 - ANGLE_BITS)) * HALF_PI_Q30) >> 30;
      th2 = (theta * theta) >> 30;
      term = theta;
      s_acc = term;
      for (int n = 1; n <= 4; n++) begin
        term = ((term * th2) >> 30) / ((2 * n) * (2 * n + 1));
        s_acc = n[0] ? s_acc - longint'(term) : s_acc + longint'(term);
      end
      term = 64'd1 << 30;
      c_acc = term;
      for (int n = 1; n <= 5; n++) begin
        term = ((term * th2) >> 30) / ((2 * n - 1) * (2 * n));
        c_acc = n[0] ? c_acc - longint'(term) : c_acc + longint'(term);
      end
      c = clamp_q14(c_acc);
      s = clamp_q14(s_acc);
      case (k[ANGLE_BITS-1 -: 2])
        QUAD0: begin gx = c; gy = s; end
        QUAD1: begin gx = -s; gy = c; end
        QUAD2: begin gx = -c; gy = -s; end
        default: begin gx = s; gy = -c; end
      endcase
    endfunction

    function longint corner_dot(longint cx, longint cy, longint dx, longint dy);
      longint gx, gy;
      gradient(mix_hash(cx[31:0], cy[31:0]), gx, gy);
      return round_shift(dx * gx + dy * gy, 14);
    endfunction

    function longint fade(longint w);
      longint t;
      t = 6 * w - 15 * ONE;
      t = round_shift(t * w, FRAC_BITS) + 10 * ONE;
      repeat (3) t = round_shift(t * w, FRAC_BITS);
      if (t < 0) t = 0;
      if (t > ONE) t = ONE;
      return t;
    endfunction

    function longint lerp(longint a0, longint a1, longint f);
      return a0 + round_shift((a1 - a0) * f, FRAC_BITS);
    endfunction

    function logic [15:0] noise_of(logic signed [31:0] x, logic signed [31:0] y);
      longint xc, yc, fx, fy, sx, sy, r0, r1, u;
      xc = longint'(x) >>> FRAC_BITS;
      yc = longint'(y) >>> FRAC_BITS;
      fx = x[FRAC_BITS-1:0];
      fy = y[FRAC_BITS-1:0];
      sx = fade(fx);
      sy = fade(fy);
      r0 = lerp(corner_dot(xc, yc, fx, fy), corner_dot(xc + 1, yc, fx - ONE, fy), sx);
      r1 = lerp(corner_dot(xc, yc + 1, fx, fy - ONE),
                corner_dot(xc + 1, yc + 1, fx - ONE, fy - ONE), sx);
      u = lerp(r0, r1, sy) + ONE;
      if (u <= 0) return 16'd0;
      if (FRAC_BITS > 15) u = (u + (longint'(1) << (FRAC_BITS - 16))) >> (FRAC_BITS - 15);
      else u = u << (15 - FRAC_BITS);
      if (u > 65535) u = 65535;
      return u[15:0];
    endfunction

    function void note_point(logic signed [31:0] x, logic signed [31:0] y);
      expected_noise.push_back(noise_of(x, y));
    endfunction

    function void check_noise(logic [15:0] actual);
      logic [15:0] want;
      if (expected_noise.size() == 0) begin
        $display("%0t: unexpected noise beat, got %0d", $time, actual);
        errors++;
        return;
      end
      want = expected_noise.pop_front();
      if (want !== actual) begin
        $display("%0t: noise_value mismatch, expected %0d, actual %0d", $time, want, actual);
        errors++;
      end
    endfunction
  endclass

  logic               clk = 0;
  logic               rst = 1;
  logic               push = 0;
  logic               pop = 0;
  logic signed [31:0] x_coord = 0;
  logic signed [31:0] y_coord = 0;
  logic               full, empty;
  logic [15:0]        noise_value;

  noise_scoreboard sb = new();
  int send_idle_pct = 28;
  int recv_idle_pct = 78;
  int hold_cycles = 0;
  bit hold_req = 0;
  bit hold_done = 0;
  int quiet_cycles = 0;
  int points_in = 0;
  int results_out = 0;

  gradient_noise_2d_top uut (.*);

  initial forever #5 clk = ~clk;

  // beat monitor: values seen here are the pre-edge ones
  always @(posedge clk) begin
    if (!rst && push && !full) begin
      sb.note_point(x_coord, y_coord);
      points_in++;
    end
    if (!rst && pop && !empty) begin
      sb.check_noise(noise_value);
      results_out++;
    end
    if (!rst && ((push && !full) || (pop && !empty))) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  // receiver, with its own long hold-off counter
  always @(posedge clk) begin
    if (rst) pop <= 0;
    else if (hold_req && !hold_done) begin
      pop <= 0;
      hold_cycles <= 200;
      hold_done <= 1;
    end else if (hold_cycles > 0) begin
      pop <= 0;
      hold_cycles <= hold_cycles - 1;
    end else pop <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (quiet_cycles >= 3000) begin
      $display("Timeout: no beat for %0d cycles", quiet_cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_point(logic signed [31:0] x, logic signed [31:0] y);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 0;
      @(posedge clk);
    end
    push <= 1;
    x_coord <= x;
    y_coord <= y;
    do @(posedge clk); while (!(push && !full));
  endtask

  task automatic drain();
    push <= 0;
    wait (sb.expected_noise.size() == 0);
    @(posedge clk);
  endtask

  task automatic send_random(int count);
    logic signed [31:0] x, y;
    repeat (count) begin
      case ($urandom_range(3))
        0: begin x = $urandom; y = $urandom; end
        1: begin  // near the origin, both signs
          x = $signed($urandom_range(32'h000fffff)) - 32'sh00080000;
          y = $signed($urandom_range(32'h000fffff)) - 32'sh00080000;
        end
        2: begin  // lattice corners and edges of the cell
          x = {16'($urandom_range(32'hffff)), 16'h0};
          y = {16'($urandom), $urandom_range(1) ? 16'hffff : 16'h0001};
        end
        default: begin x = $urandom; y = {$urandom_range(1) ? 16'h7fff : 16'h8000, 16'($urandom)}; end
      endcase
      send_point(x, y);
    end
  endtask

  initial begin
    logic signed [31:0] corner_vals [8] = '{32'sh0, 32'sh7fffffff, 32'sh80000000,
      32'shffffffff, 32'sh00010000, 32'sh0000ffff, 32'sh7fff0000, 32'sh00008000};
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: extreme and special coordinates
    send_idle_pct = 0;
    for (int i = 0; i < 8; i++) send_point(corner_vals[i], corner_vals[(i * 3) % 8]);
    for (int i = 0; i < 8; i++) send_point(corner_vals[7 - i], corner_vals[i]);
    drain();

    // phase 1, with a long receiver hold so the queue fills and full rises
    send_idle_pct = 28;
    recv_idle_pct = 78;
    hold_req <= 1;
    send_random(40);
    drain();
    send_random(240);
    drain();

    send_idle_pct = 78;
    recv_idle_pct = 28;
    send_random(280);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random(290);
    drain();

    repeat (30) @(posedge clk);
    $display("Covered %0d noise points, %0d results checked, extreme coordinates,", points_in,
             results_out);
    $display("full-range and near-lattice samples under mixed idling and a long stall.");
    if (sb.errors == 0 && sb.expected_noise.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule
